### rtl/core/slipdc_pkg.sv
// Shared types, constants and the CRC-16 byte update for the SLIP deframer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package slipdc_pkg;

  // Frame capacity and derived widths.
  localparam int MAX_FRAME_BYTES = 512;
  localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);
  localparam int LEN_W           = 10;
  localparam int CMP_W           = 17;

  // SLIP framing bytes: frame end, escape, and the escaped forms of both.
  localparam logic [7:0] FEND  = 8'hC0;
  localparam logic [7:0] FESC  = 8'hDB;
  localparam logic [7:0] TFEND = 8'hDC;
  localparam logic [7:0] TFESC = 8'hDD;

  // CRC-16/XMODEM generator polynomial.
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Configuration register indexes.
  localparam logic REG_MIN_FRAME_LEN    = 1'b0;
  localparam logic REG_CRC_FIELD_OFFSET = 1'b1;

  // Output packing widths.
  localparam int OUT_DATA_W = 56;

  // Frame status codes.
  typedef enum logic [2:0] {
    ST_NONE  = 3'd0,
    ST_GOOD  = 3'd1,
    ST_SHORT = 3'd2,
    ST_CRC   = 3'd3,
    ST_ERR   = 3'd4
  } status_t;

  // One result item.
  typedef struct packed {
    logic          byte_valid;
    logic [7:0]    byte_out;
    logic          frame_end;
    status_t       frame_status;
    logic [LEN_W-1:0] frame_length;
    logic [15:0]   crc_computed;
    logic [15:0]   crc_expected;
  } res_t;

  // Feed one byte into an MSB-first CRC-16 with the 0x1021 polynomial.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### rtl/core/slipdc_in_reg.sv
// Input register of the SLIP deframer: holds one raw link byte.
// Depends on slipdc_pkg (imported for house consistency of widths).
`timescale 1ns / 1ps

module slipdc_in_reg
  import slipdc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;

  // The register can take a new byte when empty or when its byte moves on.
  assign in_tready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
    end
  end

  assign held_valid = valid_r;
  assign held_byte  = byte_r;

endmodule

### rtl/core/slipdc_core.sv
// Per-byte SLIP decode, frame bookkeeping and CRC check for the deframer.
// Depends on slipdc_pkg for codes, the result type and the CRC update.
`timescale 1ns / 1ps

module slipdc_core
  import slipdc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_addr,
  input  logic [6:0] cfg_wdata,
  input  logic       step,
  input  logic [7:0] rx_byte,
  output res_t       res
);

  // Configuration registers.
  logic [6:0] min_len_r;
  logic [5:0] crc_off_r;

  // Frame state.
  logic             esc_r, esc_nxt;
  logic             hunt_r, hunt_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [15:0]      cap_r, cap_nxt;

  logic             take_en;
  logic [7:0]       take_d;
  logic             clear;
  logic [CMP_W-1:0] pos;
  logic [CMP_W-1:0] off_lo;
  logic [CMP_W-1:0] off_hi;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= 7'd8;
      crc_off_r <= 6'd6;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MIN_FRAME_LEN:    min_len_r <= cfg_wdata;
        REG_CRC_FIELD_OFFSET: crc_off_r <= cfg_wdata[5:0];
        default:              ;
      endcase
    end
  end

  assign pos    = CMP_W'(cnt_r);
  assign off_lo = CMP_W'(crc_off_r);
  assign off_hi = CMP_W'(crc_off_r) + CMP_W'(1);

  // Decode one byte and produce its result.
  always_comb begin
    esc_nxt  = esc_r;
    hunt_nxt = hunt_r;
    ovf_nxt  = ovf_r;
    cnt_nxt  = cnt_r;
    crc_nxt  = crc_r;
    cap_nxt  = cap_r;
    take_en  = 1'b0;
    take_d   = rx_byte;
    clear    = 1'b0;
    res      = '0;

    if (hunt_r) begin
      // Discard until END, which resynchronizes silently.
      if (rx_byte == FEND) begin
        hunt_nxt = 1'b0;
        clear    = 1'b1;
      end
    end else if (esc_r) begin
      esc_nxt = 1'b0;
      if (rx_byte == TFEND) begin
        take_en = 1'b1;
        take_d  = FEND;
      end else if (rx_byte == TFESC) begin
        take_en = 1'b1;
        take_d  = FESC;
      end else begin
        // Bad escape: END aborts at once, anything else starts hunting.
        res.frame_end    = (rx_byte == FEND);
        res.frame_status = ST_ERR;
        res.frame_length = LEN_W'(cnt_r);
        res.crc_computed = crc_r;
        res.crc_expected = cap_r;
        clear            = 1'b1;
        hunt_nxt         = (rx_byte != FEND);
      end
    end else if (rx_byte == FEND) begin
      // Close a non-empty frame; an empty one gives an all-zero result.
      if (cnt_r != '0 || ovf_r) begin
        res.frame_end    = 1'b1;
        res.frame_length = LEN_W'(cnt_r);
        res.crc_computed = crc_r;
        res.crc_expected = cap_r;
        priority if (ovf_r) begin
          res.frame_status = ST_ERR;
        end else if (pos < CMP_W'(min_len_r)) begin
          res.frame_status = ST_SHORT;
        end else if (crc_r != cap_r) begin
          res.frame_status = ST_CRC;
        end else begin
          res.frame_status = ST_GOOD;
        end
      end
      clear = 1'b1;
    end else if (rx_byte == FESC) begin
      esc_nxt = 1'b1;
    end else begin
      take_en = 1'b1;
    end

    // Store one decoded byte, or flag overflow when the frame is full.
    if (take_en) begin
      if (pos >= CMP_W'(MAX_FRAME_BYTES)) begin
        ovf_nxt = 1'b1;
      end else begin
        res.byte_valid = 1'b1;
        res.byte_out   = take_d;
        if (pos == off_lo) begin
          cap_nxt = {cap_r[15:8], take_d};
          crc_nxt = crc_feed(crc_r, 8'h00);
        end else if (pos == off_hi) begin
          cap_nxt = {take_d, cap_r[7:0]};
          crc_nxt = crc_feed(crc_r, 8'h00);
        end else begin
          crc_nxt = crc_feed(crc_r, take_d);
        end
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end

    if (clear) begin
      esc_nxt = 1'b0;
      ovf_nxt = 1'b0;
      cnt_nxt = '0;
      crc_nxt = '0;
      cap_nxt = '0;
    end
  end

  // State advances only when a byte moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r  <= 1'b0;
      hunt_r <= 1'b0;
      ovf_r  <= 1'b0;
      cnt_r  <= '0;
      crc_r  <= '0;
      cap_r  <= '0;
    end else if (step) begin
      esc_r  <= esc_nxt;
      hunt_r <= hunt_nxt;
      ovf_r  <= ovf_nxt;
      cnt_r  <= cnt_nxt;
      crc_r  <= crc_nxt;
      cap_r  <= cap_nxt;
    end
  end

endmodule

### rtl/core/slipdc_out_reg.sv
// Result register of the SLIP deframer: holds one result request until taken.
// Depends on slipdc_pkg for the result type and output packing width.
`timescale 1ns / 1ps

module slipdc_out_reg
  import slipdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  res_t                  res,
  output logic                  room,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // byte_out, frame_status, frame_length,
                                            // crc_computed, crc_expected, zero fill
  output logic                  out_tlast,  // frame_end
  output logic                  out_tuser   // byte_valid
);

  logic valid_r, valid_nxt;
  res_t res_r;

  // Room for a new result when empty or when the held one is taken now.
  assign room = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (room) begin
      valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  // Pack the fields from the lowest bit up.
  assign out_tvalid = valid_r;
  assign out_tdata  = {3'b000, res_r.crc_expected, res_r.crc_computed,
                       res_r.frame_length, res_r.frame_status, res_r.byte_out};
  assign out_tlast  = res_r.frame_end;
  assign out_tuser  = res_r.byte_valid;

endmodule

### rtl/core/slip_deframer_crc_check_top.sv
// Top level of the SLIP deframer with CRC-16/XMODEM frame check.
// Depends on slipdc_pkg, slipdc_in_reg, slipdc_core and slipdc_out_reg.
//
//   Channel   Ports                          Moves
//   in_       tvalid/tready/tdata[7:0]       one raw link byte per request
//   out_      tvalid/tready/tdata/tlast/tuser one result per raw byte
//   cfg_      we/addr/wdata[6:0]             register writes, no read-back
//
// Each raw byte is held in the input register before it moves into the result
// register, from which its result is offered. One byte per cycle is sustained
// while results are taken; the decode and CRC byte update sit between the two
// registers.
// rst_n is synchronous and active low; it clears the frame state and restores
// the register defaults. A stalled result holds the pipeline, while the input
// register still takes a byte if it is empty.
`timescale 1ns / 1ps

module slip_deframer_crc_check_top
  import slipdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] rx_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [7:0] byte_out, [10:8] frame_status,
                                            // [20:11] frame_length, [36:21] crc_computed,
                                            // [52:37] crc_expected, [55:53] zero
  output logic                  out_tlast,  // frame_end
  output logic                  out_tuser,  // [0] byte_valid
  input  logic                  cfg_we,
  input  logic                  cfg_addr,
  input  logic [6:0]            cfg_wdata
);

  logic       held_valid;
  logic [7:0] held_byte;
  logic       room;
  logic       advance;
  res_t       res;

  // A held byte moves on when the result register has room.
  assign advance = held_valid && room;

  slipdc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  slipdc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .step      (advance),
    .rx_byte   (held_byte),
    .res       (res)
  );

  slipdc_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .res        (res),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
